// ===== hw/rtl/gpio_pkg.sv =====
// Shared types and codes for the GPIO port with pin interrupts.
package gpio_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Register word offsets.
	typedef enum logic [2:0] {
		OFS_DATA     = 3'd0,
		OFS_DIR      = 3'd1,
		OFS_PAD      = 3'd2,
		OFS_CTL_LOW  = 3'd3,
		OFS_CTL_HIGH = 3'd4,
		OFS_MASK     = 3'd5,
		OFS_STATUS   = 3'd6,
		OFS_NONE     = 3'd7
	} ofs_t;

	// Per-pin trigger modes.
	typedef enum logic [1:0] {
		MODE_LOW  = 2'd0,
		MODE_HIGH = 2'd1,
		MODE_RISE = 2'd2,
		MODE_FALL = 2'd3
	} mode_t;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned HALF_PINS = 16;
	localparam int unsigned IN_W      = 72;
	localparam int unsigned OUT_W     = 104;

	// Control handed to one pin lane for the current item.
	typedef struct packed {
		logic tick;
		logic clear;
	} lane_ctl_t;

	// Interrupt lines out of the merging stage.
	typedef struct packed {
		logic high;
		logic low;
	} irq_t;

	// One result item, last field in the lowest bits.
	typedef struct packed {
		logic              irq_upper;
		logic              irq_low;
		logic [WORD_W-1:0] pad_dir;
		logic [WORD_W-1:0] pad_out;
		logic [WORD_W-1:0] read_data;
	} result_t;

	localparam int unsigned RES_W = $bits(result_t);

endpackage

// ===== hw/rtl/gpio_port_with_pin_interrupts.sv =====
// Top level of the GPIO port: register file, pin lanes, merge and output buffer.
//
//  channel   direction  tdata (low bit first)                        tuser
//  s_axis    in         reg_offset, write_data, pad_in, zero pad     kind
//  m_axis    out        read_data, pad_out, pad_dir, irq_low,        none
//                       irq_upper, zero pad
//
// The lanes and the merge are one level of logic in front of the state
// registers and the output register.
// An item is accepted each cycle while the two-entry output buffer has room;
// a stalled result sits in the output register and a second one in the skid.
// Reset clears the state registers and empties both buffer entries at once.
module gpio_port_with_pin_interrupts
	import gpio_pkg::*;
#(
	parameter int unsigned PIN_COUNT = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // reg_offset, write_data, pad_in
	input  logic [1:0]       s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // read_data, pad_out, pad_dir, irq_low, irq_upper
);

	logic in_fire;
	kind_t kind;
	ofs_t ofs;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] pads;

	logic [PIN_COUNT-1:0] data_q, dir_q, mask_q, status_q, pad_q;
	logic [WORD_W-1:0] ctl_low_q, ctl_high_q;

	logic [PIN_COUNT-1:0] data_nxt, dir_nxt, mask_nxt, status_nxt, pad_nxt;
	logic [WORD_W-1:0] ctl_low_nxt, ctl_high_nxt;
	logic [WORD_W-1:0] rdata;
	logic is_wr, is_tick;
	irq_t irq;
	result_t res;

	result_t out_q, skid_q;
	logic out_vld_q, skid_vld_q;

	// Unpack the input item.
	assign kind    = kind_t'(s_axis_tuser);
	assign ofs     = ofs_t'(s_axis_tdata[2:0]);
	assign wdata   = s_axis_tdata[34:3];
	assign pads    = s_axis_tdata[66:35];
	assign is_wr   = (kind == KIND_WRITE);
	assign is_tick = (kind == KIND_TICK);
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Register reads see the state before the item.
	always_comb begin
		rdata = '0;
		if (kind == KIND_READ) begin
			unique case (ofs)
				OFS_DATA:     rdata = WORD_W'(data_q);
				OFS_DIR:      rdata = WORD_W'(dir_q);
				OFS_PAD:      rdata = WORD_W'(pad_q);
				OFS_CTL_LOW:  rdata = ctl_low_q;
				OFS_CTL_HIGH: rdata = ctl_high_q;
				OFS_MASK:     rdata = WORD_W'(mask_q);
				OFS_STATUS:   rdata = WORD_W'(status_q);
				OFS_NONE:     rdata = '0;
			endcase
		end
	end

	// Next values of the plain word registers.
	always_comb begin
		data_nxt     = (is_wr && ofs == OFS_DATA) ? wdata[PIN_COUNT-1:0] : data_q;
		dir_nxt      = (is_wr && ofs == OFS_DIR) ? wdata[PIN_COUNT-1:0] : dir_q;
		mask_nxt     = (is_wr && ofs == OFS_MASK) ? wdata[PIN_COUNT-1:0] : mask_q;
		ctl_low_nxt  = (is_wr && ofs == OFS_CTL_LOW) ? wdata : ctl_low_q;
		ctl_high_nxt = (is_wr && ofs == OFS_CTL_HIGH) ? wdata : ctl_high_q;
		pad_nxt      = is_tick ? pads[PIN_COUNT-1:0] : pad_q;
	end

	// One detection lane per pin.
	for (genvar i = 0; i < PIN_COUNT; i++) begin : g_lane
		localparam int unsigned SLOT = i % HALF_PINS;
		mode_t mode;
		lane_ctl_t ctl;

		if (i < HALF_PINS) begin : g_lo
			assign mode = mode_t'(ctl_low_q[2*SLOT +: 2]);
		end else begin : g_hi
			assign mode = mode_t'(ctl_high_q[2*SLOT +: 2]);
		end

		assign ctl.tick  = is_tick;
		assign ctl.clear = is_wr && (ofs == OFS_STATUS) && wdata[i];

		gpio_pin_lane u_lane (
			.mode       (mode),
			.pad_now    (pads[i]),
			.pad_old    (pad_q[i]),
			.status     (status_q[i]),
			.ctl        (ctl),
			.status_nxt (status_nxt[i])
		);
	end

	// Interrupt lines from the state after the item.
	gpio_irq_merge #(
		.PIN_COUNT (PIN_COUNT)
	) u_merge (
		.pending (status_nxt & mask_nxt),
		.irq     (irq)
	);

	// Assemble the result item.
	always_comb begin
		res.read_data = rdata;
		res.pad_out   = WORD_W'(data_nxt);
		res.pad_dir   = WORD_W'(dir_nxt);
		res.irq_low   = irq.low;
		res.irq_upper = irq.high;
	end

	// State registers advance on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q     <= '0;
			dir_q      <= '0;
			mask_q     <= '0;
			status_q   <= '0;
			pad_q      <= '0;
			ctl_low_q  <= '0;
			ctl_high_q <= '0;
		end else if (in_fire) begin
			data_q     <= data_nxt;
			dir_q      <= dir_nxt;
			mask_q     <= mask_nxt;
			status_q   <= status_nxt;
			pad_q      <= pad_nxt;
			ctl_low_q  <= ctl_low_nxt;
			ctl_high_q <= ctl_high_nxt;
		end
	end

	// Output register with a skid entry behind it.
	assign s_axis_tready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || m_axis_tready) begin
				out_vld_q  <= skid_vld_q || in_fire;
				skid_vld_q <= 1'b0;
			end else if (in_fire) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// Payload of the buffer entries.
	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OUT_W - RES_W)'(0), out_q};

endmodule

// ===== hw/rtl/gpio_pin_lane.sv =====
// One pin lane: trigger detection and next value of the pin's status bit.
module gpio_pin_lane
	import gpio_pkg::*;
(
	input  mode_t     mode,
	input  logic      pad_now,
	input  logic      pad_old,
	input  logic      status,
	input  lane_ctl_t ctl,
	output logic      status_nxt
);

	logic hit;

	// Condition of the pin under its trigger mode.
	always_comb begin
		unique case (mode)
			MODE_LOW:  hit = ~pad_now;
			MODE_HIGH: hit = pad_now;
			MODE_RISE: hit = pad_now & ~pad_old;
			MODE_FALL: hit = ~pad_now & pad_old;
		endcase
	end

	// A tick on which the trigger hits sets the sticky bit; a status write of one clears it.
	always_comb begin
		priority if (ctl.tick) begin
			status_nxt = status | hit;
		end else if (ctl.clear) begin
			status_nxt = 1'b0;
		end else begin
			status_nxt = status;
		end
	end

endmodule

// ===== hw/rtl/gpio_irq_merge.sv =====
// Merging stage: folds the masked pending bits of all lanes into two lines.
module gpio_irq_merge
	import gpio_pkg::*;
#(
	parameter int unsigned PIN_COUNT = 32
) (
	input  logic [PIN_COUNT-1:0] pending,
	output irq_t                 irq
);

	logic [WORD_W-1:0] pending_w;

	// Lower half of the pins drives the low line, upper half the high line.
	always_comb begin
		pending_w = WORD_W'(pending);
		irq.low   = |pending_w[HALF_PINS-1:0];
		irq.high  = |pending_w[WORD_W-1:HALF_PINS];
	end

endmodule

// ===== hw/rtl/gpio_checker.sv =====
// Port-level checks of the GPIO port, bound to the top level.
module gpio_checker
	import gpio_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic [1:0]       s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Every accepted item leaves a result waiting in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted item produced no result");

	// Back pressure only while results are buffered.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// Non-reads and reads of the unused offset return zero read data.
	a_rzero: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
		(s_axis_tuser != KIND_READ || s_axis_tdata[2:0] == OFS_NONE)
		|=> m_axis_tdata[31:0] == '0)
		else $error("read data not zero");

endmodule

bind gpio_port_with_pin_interrupts gpio_checker u_gpio_checker (.*);
